### src/compacting_indexed_stack_assert.svh
// ============================================================================
// Assertion macros for the compacting indexed stack
// Immediate-style wrappers around concurrent assertions on clk and rst.
// ============================================================================
`ifndef COMPACTING_INDEXED_STACK_ASSERT_SVH
`define COMPACTING_INDEXED_STACK_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define CIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by another.
`define CIS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define CIS_ASSERT(label, prop, msg)
`define CIS_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

### src/cis_pkg.sv
// ============================================================================
// Compacting indexed stack package
// Operation and status codes, field widths and default sizes.
// ============================================================================
package cis_pkg;

  // Default sizes of the store.
  localparam int unsigned DefaultDepth     = 256;
  localparam int unsigned DefaultDataWidth = 32;

  // Widths of the request and response fields.
  localparam int unsigned OpWidth     = 3;
  localparam int unsigned PosWidth    = 8;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned FillWidth   = 9;

  // Request operations.
  typedef enum logic [OpWidth-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_SET    = 3'd2,
    OP_GET    = 3'd3,
    OP_REMOVE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  // Response status codes.
  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

### src/cis_if.sv
// ============================================================================
// Compacting indexed stack channels
// Valid/ready request and response channels with their payloads.
// ============================================================================

// Request channel: one operation with its index and data.
interface cis_req_if;
  logic                                valid;
  logic                                ready;
  logic [cis_pkg::OpWidth-1:0]         operation;
  logic [cis_pkg::PosWidth-1:0]        position;
  logic [cis_pkg::ValueWidth-1:0]      entry_value;

  modport source (output valid, output operation, output position,
                  output entry_value, input ready);
  modport sink (input valid, input operation, input position,
                input entry_value, output ready);
endinterface

// Response channel: one result for each request.
interface cis_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [cis_pkg::ValueWidth-1:0]      read_value;
  logic [cis_pkg::StatusWidth-1:0]     status;
  logic [cis_pkg::FillWidth-1:0]       fill_count;

  modport source (output valid, output read_value, output status,
                  output fill_count, input ready);
  modport sink (input valid, input read_value, input status,
                input fill_count, output ready);
endinterface

### src/cis_ram.sv
// ============================================================================
// Compacting indexed stack entry memory
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module cis_ram #(
  parameter int unsigned DEPTH      = cis_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = cis_pkg::DefaultDataWidth
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_WIDTH-1:0]      wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_WIDTH-1:0]      rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/compacting_indexed_stack.sv
// Requests are handled one at a time. Push, set, clear and refused requests pass from
// acceptance straight to the finish state; pop and get pass through a read state first;
// a remove below the top moves each later entry down, one entry a cycle through the
// single RAM write port. The next request is taken in the cycle after the result is
// loaded. Reset (rst, synchronous) empties the store at once; entry data is not
// cleared.
// ============================================================================
// Compacting indexed stack
// Bounded stack with indexed set, get and remove; remove closes the gap by
// moving later entries down one per cycle through a synchronous RAM.
// ============================================================================
`include "compacting_indexed_stack_assert.svh"

module compacting_indexed_stack #(
  parameter int unsigned DEPTH      = cis_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = cis_pkg::DefaultDataWidth
) (
  input logic          clk,
  input logic          rst,
  cis_req_if.sink      req,
  cis_rsp_if.source    rsp
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > cis_pkg::PosWidth) ? CW : cis_pkg::PosWidth;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [AW-1:0]          shift_idx;
  logic [DATA_WIDTH-1:0]  res_value;
  cis_pkg::status_t       res_status;

  logic                            rsp_valid;
  logic [cis_pkg::ValueWidth-1:0]  rsp_value;
  cis_pkg::status_t                rsp_status;
  logic [cis_pkg::FillWidth-1:0]   rsp_count;

  logic                   fire;
  cis_pkg::op_t           op;
  logic [CMPW-1:0]        pos_ext;
  logic [CMPW-1:0]        cnt_ext;
  logic [AW-1:0]          pos_idx;
  logic [AW-1:0]          top_idx;
  logic                   in_range;
  logic                   full;
  logic                   empty;
  logic [DATA_WIDTH-1:0]  val_w;
  logic                   push_ok;
  logic                   load_rsp;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [DATA_WIDTH-1:0]  mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [DATA_WIDTH-1:0]  mem_rdata;

  // Request decode.
  assign req.ready = (state == S_IDLE);
  assign fire      = req.valid && req.ready;
  assign op        = cis_pkg::op_t'(req.operation);
  assign pos_ext   = CMPW'(req.position);
  assign cnt_ext   = CMPW'(count);
  assign pos_idx   = pos_ext[AW-1:0];
  assign top_idx   = count[AW-1:0];
  assign in_range  = pos_ext < cnt_ext;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign val_w     = DATA_WIDTH'(req.entry_value);
  assign push_ok   = fire && (op == cis_pkg::OP_PUSH) && !full;
  assign load_rsp  = (state == S_FINISH) && (!rsp_valid || rsp.ready);

  // Memory port selection for the accepting cycle and the shift loop.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = top_idx;
    mem_wdata = val_w;
    mem_re    = 1'b0;
    mem_raddr = pos_idx;
    if (fire) begin
      case (op)
        cis_pkg::OP_PUSH: begin
          mem_we = !full;
        end
        cis_pkg::OP_POP: begin
          mem_re    = !empty;
          mem_raddr = AW'(top_idx - AW'(1));
        end
        cis_pkg::OP_SET: begin
          mem_we    = in_range;
          mem_waddr = pos_idx;
        end
        cis_pkg::OP_GET: begin
          mem_re = in_range;
        end
        cis_pkg::OP_REMOVE: begin
          mem_re    = in_range;
          mem_raddr = AW'(pos_idx + AW'(1));
        end
        default: begin
          mem_re = 1'b0;
        end
      endcase
    end else if (state == S_SHIFT) begin
      mem_we    = 1'b1;
      mem_waddr = shift_idx;
      mem_wdata = mem_rdata;
      mem_re    = 1'b1;
      mem_raddr = AW'(shift_idx + AW'(2));
    end
  end

  cis_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer, fill count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (fire) begin
            res_value <= '0;
            case (op)
              cis_pkg::OP_PUSH: begin
                state <= S_FINISH;
                if (full) begin
                  res_status <= cis_pkg::ST_FULL;
                end else begin
                  res_status <= cis_pkg::ST_OK;
                  count      <= CW'(count + CW'(1));
                end
              end
              cis_pkg::OP_POP: begin
                if (empty) begin
                  res_status <= cis_pkg::ST_RANGE;
                  state      <= S_FINISH;
                end else begin
                  res_status <= cis_pkg::ST_OK;
                  count      <= CW'(count - CW'(1));
                  state      <= S_READ;
                end
              end
              cis_pkg::OP_SET: begin
                res_status <= in_range ? cis_pkg::ST_OK : cis_pkg::ST_RANGE;
                state      <= S_FINISH;
              end
              cis_pkg::OP_GET: begin
                res_status <= in_range ? cis_pkg::ST_OK : cis_pkg::ST_RANGE;
                state      <= in_range ? S_READ : S_FINISH;
              end
              cis_pkg::OP_REMOVE: begin
                if (!in_range) begin
                  res_status <= cis_pkg::ST_RANGE;
                  state      <= S_FINISH;
                end else begin
                  res_status <= cis_pkg::ST_OK;
                  count      <= CW'(count - CW'(1));
                  // Removing the last entry needs no shift.
                  if (CMPW'(pos_ext + CMPW'(1)) != cnt_ext) begin
                    shift_idx <= pos_idx;
                    state     <= S_SHIFT;
                  end else begin
                    state <= S_FINISH;
                  end
                end
              end
              cis_pkg::OP_CLEAR: begin
                res_status <= cis_pkg::ST_OK;
                count      <= '0;
                state      <= S_FINISH;
              end
              default: begin
                res_status <= cis_pkg::ST_RANGE;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_READ: begin
          res_value <= mem_rdata;
          state     <= S_FINISH;
        end
        S_SHIFT: begin
          // The entry just written was the last one below the new count.
          if (CW'(CW'(shift_idx) + CW'(1)) == count) begin
            state <= S_FINISH;
          end else begin
            shift_idx <= AW'(shift_idx + AW'(1));
          end
        end
        S_FINISH: begin
          if (load_rsp) begin
            rsp_value  <= cis_pkg::ValueWidth'(res_value);
            rsp_status <= res_status;
            rsp_count  <= cis_pkg::FillWidth'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response outputs.
  assign rsp.valid      = rsp_valid;
  assign rsp.read_value = rsp_value;
  assign rsp.status     = rsp_status;
  assign rsp.fill_count = rsp_count;

  // Checks on the sequencer.
  `CIS_ASSERT(a_count_bound, count <= CW'(DEPTH), "fill count exceeds depth")
  `CIS_ASSERT(a_shift_in_store,
              (state != S_SHIFT) || (CW'(shift_idx) < count),
              "shift beyond fill count")
  `CIS_ASSERT(a_full_only_at_depth,
              (state != S_FINISH) || (res_status != cis_pkg::ST_FULL) || full,
              "full status below depth")
  `CIS_ASSERT_NEXT(a_push_grows, push_ok,
                   count == CW'($past(count) + CW'(1)),
                   "accepted push did not grow count")
  `CIS_ASSERT_NEXT(a_read_done, state == S_READ, state == S_FINISH,
                   "read did not finish in one cycle")

endmodule
